>>> src/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// Shared sizes, command codes and payload types of the priority scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

  // Table size and derived index widths
  localparam int MAX_PROCESSES = 16;
  localparam int IDX_W         = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int CNT_W         = $clog2(MAX_PROCESSES + 1);

  // Fixed field widths
  localparam int SLOT_W  = 4;
  localparam int TIME_W  = 16;
  localparam int PRIO_W  = 7;
  localparam int CLOCK_W = 32;

  // Highest priority number a slot may hold
  localparam logic [PRIO_W-1:0] PRIO_CAP = 7'd99;

  // Command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [CLOCK_W-1:0] clock_t;

  typedef struct packed {
    logic              command;
    slot_t             slot;
    logic [TIME_W-1:0] arrival_time;
    logic [TIME_W-1:0] burst_time;
    logic [PRIO_W-1:0] prio_level;
  } item_t;

  typedef struct packed {
    logic   ran_valid;
    slot_t  ran_slot;
    clock_t time_now;
    logic   finished;
    clock_t first_run_time;
    clock_t completion_time;
    clock_t turnaround;
    clock_t total_turnaround;
    logic   all_done;
  } result_t;

  // One row of the process table
  typedef struct packed {
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] remaining;
    clock_t            start;
  } rec_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic scan_step;
    logic commit_load;
    logic commit_tick;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic new_tick;
    logic scan_done;
  } ctl_sts_t;

endpackage

>>> src/pps_datapath.sv
// ----------------------------------------------------------------------------
// pps_datapath
// Process table, slot scan with best-candidate registers, tick update and
// result register.
// ----------------------------------------------------------------------------
module pps_datapath (
  input  logic               clk,
  input  logic               rst,
  input  pps_pkg::item_t     item,
  input  pps_pkg::ctl_cmd_t  cmd,
  output pps_pkg::ctl_sts_t  sts,
  output pps_pkg::result_t   result
);

  pps_pkg::rec_t   table_mem [pps_pkg::MAX_PROCESSES];
  pps_pkg::item_t  req;
  logic [pps_pkg::MAX_PROCESSES-1:0] loaded;
  logic [pps_pkg::MAX_PROCESSES-1:0] done;
  logic [pps_pkg::MAX_PROCESSES-1:0] loaded_next;
  logic [pps_pkg::MAX_PROCESSES-1:0] done_next;
  pps_pkg::clock_t clock_time;
  pps_pkg::clock_t turn_sum;
  pps_pkg::cnt_t   scan_cnt;
  pps_pkg::rec_t   rd_rec;
  pps_pkg::idx_t   rd_idx;
  logic            rd_live;
  pps_pkg::rec_t   best_rec;
  pps_pkg::idx_t   best_idx;
  logic            best_valid;
  pps_pkg::result_t result_reg;

  logic            scan_issue;
  pps_pkg::idx_t   scan_idx;
  logic            elig;
  logic            better;
  logic            load_ok;
  pps_pkg::idx_t   load_idx;
  logic [pps_pkg::PRIO_W-1:0] load_prio;
  pps_pkg::rec_t   load_rec;
  pps_pkg::clock_t first_run;
  pps_pkg::clock_t clock_inc;
  pps_pkg::clock_t turn;
  logic            fin;
  logic            fin_hit;
  pps_pkg::rec_t   upd_rec;
  logic            wr_en;
  pps_pkg::idx_t   wr_idx;
  pps_pkg::rec_t   wr_rec;
  logic            all_done_next;

  // Scan addressing
  assign scan_issue = cmd.scan_step && (scan_cnt < pps_pkg::cnt_t'(pps_pkg::MAX_PROCESSES));
  assign scan_idx   = scan_cnt[pps_pkg::IDX_W-1:0];

  assign sts.new_tick  = (item.command == pps_pkg::CMD_TICK);
  assign sts.scan_done = (scan_cnt == pps_pkg::cnt_t'(pps_pkg::MAX_PROCESSES));

  // Candidate test on the row just read
  assign elig = loaded[rd_idx] && !done[rd_idx] &&
                (pps_pkg::clock_t'(rd_rec.arrival) <= clock_time);
  assign better = !best_valid || (rd_rec.prio < best_rec.prio) ||
                  ((rd_rec.prio == best_rec.prio) && (rd_rec.arrival < best_rec.arrival));

  // Load row
  assign load_ok   = (int'(req.slot) < pps_pkg::MAX_PROCESSES);
  assign load_idx  = pps_pkg::idx_t'(req.slot);
  assign load_prio = (req.prio_level > pps_pkg::PRIO_CAP) ? pps_pkg::PRIO_CAP : req.prio_level;

  always_comb begin
    load_rec           = '0;
    load_rec.arrival   = req.arrival_time;
    load_rec.burst     = req.burst_time;
    load_rec.prio      = load_prio;
    load_rec.remaining = req.burst_time;
  end

  // Run the chosen slot for one time unit
  assign first_run = (best_rec.remaining == best_rec.burst) ? clock_time : best_rec.start;
  assign clock_inc = clock_time + 1'b1;
  assign fin       = (best_rec.remaining <= 16'd1);
  assign fin_hit   = best_valid && fin;
  assign turn      = clock_inc - pps_pkg::clock_t'(best_rec.arrival);

  always_comb begin
    upd_rec           = best_rec;
    upd_rec.start     = first_run;
    upd_rec.remaining = fin ? '0 : best_rec.remaining - 1'b1;
  end

  // Table write port
  always_comb begin
    wr_en  = 1'b0;
    wr_idx = load_idx;
    wr_rec = load_rec;
    if (cmd.commit_load && load_ok) begin
      wr_en = 1'b1;
    end else if (cmd.commit_tick && best_valid) begin
      wr_en  = 1'b1;
      wr_idx = best_idx;
      wr_rec = upd_rec;
    end
  end

  // Flag updates
  always_comb begin
    loaded_next = loaded;
    done_next   = done;
    if (cmd.commit_load && load_ok) begin
      loaded_next[load_idx] = 1'b1;
      done_next[load_idx]   = 1'b0;
    end
    if (cmd.commit_tick && fin_hit) begin
      done_next[best_idx] = 1'b1;
    end
  end
  assign all_done_next = ~|(loaded_next & ~done_next);

  // Process table: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_idx] <= wr_rec;
    end
    rd_rec <= table_mem[scan_idx];
    rd_idx <= scan_idx;
  end

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req <= item;
    end
  end

  // Control state of the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded     <= '0;
      done       <= '0;
      clock_time <= '0;
      turn_sum   <= '0;
      scan_cnt   <= '0;
      rd_live    <= 1'b0;
      best_valid <= 1'b0;
    end else begin
      loaded  <= loaded_next;
      done    <= done_next;
      rd_live <= scan_issue;
      if (cmd.accept) begin
        scan_cnt   <= '0;
        best_valid <= 1'b0;
      end else begin
        if (scan_issue) begin
          scan_cnt <= scan_cnt + 1'b1;
        end
        if (rd_live && elig && better) begin
          best_valid <= 1'b1;
        end
      end
      if (cmd.commit_tick) begin
        clock_time <= clock_inc;
        if (fin_hit) begin
          turn_sum <= turn_sum + turn;
        end
      end
    end
  end

  // Best candidate so far
  always_ff @(posedge clk) begin
    if (rd_live && elig && better) begin
      best_rec <= rd_rec;
      best_idx <= rd_idx;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit_load) begin
      result_reg.ran_valid        <= 1'b0;
      result_reg.ran_slot         <= '0;
      result_reg.time_now         <= clock_time;
      result_reg.finished         <= 1'b0;
      result_reg.first_run_time   <= '0;
      result_reg.completion_time  <= '0;
      result_reg.turnaround       <= '0;
      result_reg.total_turnaround <= turn_sum;
      result_reg.all_done         <= all_done_next;
    end else if (cmd.commit_tick) begin
      result_reg.ran_valid        <= best_valid;
      result_reg.ran_slot         <= best_valid ? pps_pkg::slot_t'(best_idx) : '0;
      result_reg.time_now         <= clock_inc;
      result_reg.finished         <= fin_hit;
      result_reg.first_run_time   <= best_valid ? first_run : '0;
      result_reg.completion_time  <= fin_hit ? clock_inc : '0;
      result_reg.turnaround       <= fin_hit ? turn : '0;
      result_reg.total_turnaround <= fin_hit ? turn_sum + turn : turn_sum;
      result_reg.all_done         <= all_done_next;
    end
  end

  assign result = result_reg;

endmodule

>>> src/pps_ctrl.sv
// ----------------------------------------------------------------------------
// pps_ctrl
// Sequencer: accept an item, run the slot scan for a tick, commit the
// result into the output register when it is free.
// ----------------------------------------------------------------------------
module pps_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  output logic              result_valid,
  input  logic              result_ready,
  input  pps_pkg::ctl_sts_t sts,
  output pps_pkg::ctl_cmd_t cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LOAD   = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_UPDATE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_full;
  logic       out_free;

  assign out_free = !out_full || result_ready;

  // Next state and commands
  always_comb begin
    state_next      = state;
    item_ready      = 1'b0;
    cmd.accept      = 1'b0;
    cmd.scan_step   = 1'b0;
    cmd.commit_load = 1'b0;
    cmd.commit_tick = 1'b0;
    case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.accept = 1'b1;
          state_next = sts.new_tick ? S_SCAN : S_LOAD;
        end
      end
      S_LOAD: begin
        if (out_free) begin
          cmd.commit_load = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (out_free) begin
          cmd.commit_tick = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and output-valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit_load || cmd.commit_tick) begin
        out_full <= 1'b1;
      end else if (result_ready) begin
        out_full <= 1'b0;
      end
    end
  end

  assign result_valid = out_full;

endmodule

>>> src/preemptive_priority_scheduler_top.sv
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_top
// Priority scheduler over a table of process slots, one item per command.
// ----------------------------------------------------------------------------
// Every item gives exactly one result. A load item writes its slot and
// places its result in the output register once that register is free. A
// tick item reads the slot table through its single read port, one slot per
// cycle, keeping the best candidate, then updates the chosen slot and places
// its result in the output register once that register is free. The next
// item is taken once the current one is in the output register, so a result
// may wait there while the following item is already being worked on; a
// stalled receiver then holds the next result and blocks the input. No
// clearing pass is needed after reset; an item may be sent in the first cycle
// after reset.
module preemptive_priority_scheduler_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  pps_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output pps_pkg::result_t result
);

  pps_pkg::ctl_cmd_t cmd;
  pps_pkg::ctl_sts_t sts;

  // Sequencer
  pps_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  // Table, scan and result datapath
  pps_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .sts    (sts),
    .result (result)
  );

endmodule

>>> src/pps_checker.sv
// ----------------------------------------------------------------------------
// pps_checker
// Port-level checks of the scheduler, attached to the top level by bind.
// ----------------------------------------------------------------------------
module pps_checker (
  input logic             clk,
  input logic             rst,
  input logic             result_valid,
  input logic             result_ready,
  input pps_pkg::result_t result
);

  // Hold a stalled result
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result dropped or changed while stalled");

  // A completion belongs to a slot that ran
  a_fin_ran: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.finished |-> result.ran_valid)
    else $error("finished without a running slot");

  // Completion time equals the clock after the tick
  a_fin_time: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.finished |-> result.completion_time == result.time_now)
    else $error("completion time differs from current time");

  // No slot ran: per-process fields are zero
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.ran_valid |->
      result.ran_slot == '0 && result.first_run_time == '0 &&
      result.turnaround == '0)
    else $error("per-process fields set without a running slot");

endmodule

bind preemptive_priority_scheduler_top pps_checker u_pps_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
